### hw/rtl/ttd_pkg.sv
// shared types and constants for the touch tap detector
`default_nettype none

package ttd_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int POS_W       = 16;
	localparam int CFG_W       = 16;
	localparam int TIME_W      = 32;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_W-1:0] MOVE_SLOP_RST   = CFG_W'(24);
	localparam logic [CFG_W-1:0] MAX_HOLD_MS_RST = CFG_W'(1200);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOVE_SLOP   = 1'b0,
		REG_MAX_HOLD_MS = 1'b1
	} ttd_reg_t;

	typedef struct packed {
		logic [CFG_W-1:0] move_slop;
		logic [CFG_W-1:0] max_hold_ms;
	} ttd_cfg_t;

	typedef struct packed {
		logic                   touching;
		logic [COORD_WIDTH-1:0] x;
		logic [COORD_WIDTH-1:0] y;
		logic                   map_ok;
		logic [TIME_W-1:0]      now;
	} ttd_item_t;

endpackage

`default_nettype wire

### hw/rtl/touch_tap_detector.sv
// top level of the touch tap detector
//
// Single-tap detector for a touch panel. One frame is taken per clock cycle
// while in_stall is low: a frame is registered on input, processed against the
// gesture state once it may advance, and a tap (if any) is written to the
// output register as that frame is processed, so throughput is one frame per
// cycle while the output side takes results. The output register is the only
// place a tap waits; in_stall rises only when a frame is pending and a tap is
// held by out_stall. Contact frames with map_ok low are dropped, release frames
// ignore position and map_ok. Config registers (0 move_slop, 1 max_hold_ms) are
// always ready and should be written only while no frame is in flight.
`default_nettype none

module touch_tap_detector
	import ttd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 touching,
	input  wire logic [POS_W-1:0]     pos_x,
	input  wire logic [POS_W-1:0]     pos_y,
	input  wire logic                 map_ok,
	input  wire logic [TIME_W-1:0]    now_ms,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [POS_W-1:0]          tap_x,
	output logic [POS_W-1:0]          tap_y,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	ttd_cfg_t               cfg;
	ttd_item_t              item_s1;
	logic                   valid_s1;
	logic                   advance;
	logic                   in_acc;
	logic                   hit;
	logic [COORD_WIDTH-1:0] hit_x;
	logic [COORD_WIDTH-1:0] hit_y;
	logic                   out_valid_q;
	logic [POS_W-1:0]       tap_x_q;
	logic [POS_W-1:0]       tap_y_q;

	assign cfg_ready = 1'b1;

	ttd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// frame moves on unless a tap is held in the output register
	assign advance  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.touching <= touching;
			item_s1.x        <= pos_x[COORD_WIDTH-1:0];
			item_s1.y        <= pos_y[COORD_WIDTH-1:0];
			item_s1.map_ok   <= map_ok;
			item_s1.now      <= now_ms;
		end
	end

	ttd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.hit    (hit),
		.hit_x  (hit_x),
		.hit_y  (hit_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= hit;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			tap_x_q <= POS_W'(hit_x);
			tap_y_q <= POS_W'(hit_y);
		end
	end

	assign out_valid = out_valid_q;
	assign tap_x     = tap_x_q;
	assign tap_y     = tap_y_q;

`ifndef SYNTHESIS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a held tap");

	a_tap_from_frame: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && hit))
		else $error("tap appeared without a processed frame");

	a_held_tap_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(tap_x_q) && $stable(tap_y_q)))
		else $error("held tap was lost or changed");
`endif

endmodule

`default_nettype wire

### hw/rtl/ttd_cfg.sv
// configuration registers of the touch tap detector
`default_nettype none

module ttd_cfg
	import ttd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data,
	output ttd_cfg_t                  cfg
);

	ttd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.move_slop   <= MOVE_SLOP_RST;
			cfg_q.max_hold_ms <= MAX_HOLD_MS_RST;
		end else if (wr_en) begin
			unique case (ttd_reg_t'(wr_index))
				REG_MOVE_SLOP:   cfg_q.move_slop   <= wr_data;
				REG_MAX_HOLD_MS: cfg_q.max_hold_ms <= wr_data;
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/ttd_core.sv
// gesture state and tap decision for one touch frame
`default_nettype none

module ttd_core
	import ttd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   fire,
	input  wire ttd_item_t              item,
	input  wire ttd_cfg_t               cfg,
	output logic                        hit,
	output logic [COORD_WIDTH-1:0]      hit_x,
	output logic [COORD_WIDTH-1:0]      hit_y
);

	logic                   pressed_q;
	logic                   moved_q;
	logic [COORD_WIDTH-1:0] start_x_q;
	logic [COORD_WIDTH-1:0] start_y_q;
	logic [COORD_WIDTH-1:0] last_x_q;
	logic [COORD_WIDTH-1:0] last_y_q;
	logic [TIME_W-1:0]      start_time_q;

	logic [COORD_WIDTH-1:0] dx;
	logic [COORD_WIDTH-1:0] dy;
	logic                   far;
	logic [TIME_W-1:0]      held;
	logic                   contact;

	assign dx = (item.x > start_x_q) ? (item.x - start_x_q) : (start_x_q - item.x);
	assign dy = (item.y > start_y_q) ? (item.y - start_y_q) : (start_y_q - item.y);
	assign far = (CFG_W'(dx) > cfg.move_slop) || (CFG_W'(dy) > cfg.move_slop);
	assign held = item.now - start_time_q;
	assign contact = item.touching && item.map_ok;

	assign hit = fire && !item.touching && pressed_q && !moved_q
		&& (held < TIME_W'(cfg.max_hold_ms));
	assign hit_x = last_x_q;
	assign hit_y = last_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q    <= 1'b0;
			moved_q      <= 1'b0;
			start_x_q    <= '0;
			start_y_q    <= '0;
			last_x_q     <= '0;
			last_y_q     <= '0;
			start_time_q <= '0;
		end else if (fire) begin
			if (contact) begin
				last_x_q <= item.x;
				last_y_q <= item.y;
				if (!pressed_q) begin
					pressed_q    <= 1'b1;
					moved_q      <= 1'b0;
					start_x_q    <= item.x;
					start_y_q    <= item.y;
					start_time_q <= item.now;
				end else if (far) begin
					moved_q <= 1'b1;
				end
			end else if (!item.touching) begin
				pressed_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_tap_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> (pressed_q && !moved_q && !item.touching))
		else $error("tap without a clean press");

	a_contact_sets_press: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && contact) |=> pressed_q)
		else $error("contact did not register a press");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !item.touching) |=> !pressed_q)
		else $error("release did not clear the press");
`endif

endmodule

`default_nettype wire

### tb/touch_tap_detector_tb.sv
// testbench for the touch tap detector: directed gestures, config extremes, random gestures and back-pressure
`default_nettype none

module touch_tap_detector_tb;
	import ttd_pkg::*;

	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 400;

	typedef struct {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
	} tap_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 touching = 1'b0;
	logic [POS_W-1:0]     pos_x = '0;
	logic [POS_W-1:0]     pos_y = '0;
	logic                 map_ok = 1'b0;
	logic [TIME_W-1:0]    now_ms = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [POS_W-1:0]     tap_x;
	logic [POS_W-1:0]     tap_y;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// gesture state mirrored from the block
	logic                   g_pressed = 1'b0;
	logic                   g_moved = 1'b0;
	logic [COORD_WIDTH-1:0] g_start_x = '0;
	logic [COORD_WIDTH-1:0] g_start_y = '0;
	logic [COORD_WIDTH-1:0] g_last_x = '0;
	logic [COORD_WIDTH-1:0] g_last_y = '0;
	logic [TIME_W-1:0]      g_start_t = '0;
	logic [CFG_W-1:0]       slop_cfg = MOVE_SLOP_RST;
	logic [CFG_W-1:0]       hold_cfg = MAX_HOLD_MS_RST;

	tap_t pending_taps[$];
	int   mismatches = 0;
	int   in_idle_pct = 18;
	int   out_idle_pct = 18;
	logic hold_req = 1'b0;
	int   hold_left = 0;

	touch_tap_detector dut (.*);

	always #5 clk = ~clk;

	function automatic ttd_item_t make_frame(input logic t, input logic [POS_W-1:0] x,
			input logic [POS_W-1:0] y, input logic ok, input logic [TIME_W-1:0] now);
		ttd_item_t f;
		f.touching = t;
		f.x        = x;
		f.y        = y;
		f.map_ok   = ok;
		f.now      = now;
		return f;
	endfunction

	// advance the gesture state by one frame and queue the tap it yields
	task automatic track_frame(input ttd_item_t f);
		logic [COORD_WIDTH-1:0] cx;
		logic [COORD_WIDTH-1:0] cy;
		logic [TIME_W-1:0]      held;
		tap_t                   t;
		cx = f.x[COORD_WIDTH-1:0];
		cy = f.y[COORD_WIDTH-1:0];
		if (f.touching) begin
			if (f.map_ok) begin
				if (!g_pressed) begin
					g_pressed = 1'b1;
					g_moved   = 1'b0;
					g_start_x = cx;
					g_start_y = cy;
					g_last_x  = cx;
					g_last_y  = cy;
					g_start_t = f.now;
				end else begin
					g_last_x = cx;
					g_last_y = cy;
					if ((cx > g_start_x ? cx - g_start_x : g_start_x - cx) > slop_cfg ||
						(cy > g_start_y ? cy - g_start_y : g_start_y - cy) > slop_cfg)
						g_moved = 1'b1;
				end
			end
		end else if (g_pressed) begin
			held = f.now - g_start_t;
			g_pressed = 1'b0;
			if (!g_moved && held < TIME_W'(hold_cfg)) begin
				t.x = POS_W'(g_last_x);
				t.y = POS_W'(g_last_y);
				pending_taps.push_back(t);
			end
		end
	endtask

	task automatic send_frame(input ttd_item_t f);
		while ($urandom_range(99) < in_idle_pct) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		touching = f.touching;
		pos_x    = f.x;
		pos_y    = f.y;
		map_ok   = f.map_ok;
		now_ms   = f.now;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		track_frame(f);
	endtask

	task automatic drain_frames();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_taps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input ttd_reg_t idx, input logic [CFG_W-1:0] val);
		drain_frames();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_MOVE_SLOP: slop_cfg = val;
			REG_MAX_HOLD_MS: hold_cfg = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// an optional stray release, one press, some tracking frames, one release; counts frames that are not dropped
	task automatic play_gesture(output int sent);
		int               sx;
		int               sy;
		int               nx;
		int               ny;
		int               span;
		int               r;
		logic [TIME_W-1:0] t0;
		logic [TIME_W-1:0] held;
		sent = 0;
		span = int'(slop_cfg) + 2;
		sx = $urandom_range(0, 65535);
		sy = $urandom_range(0, 65535);
		if ($urandom_range(9) == 0)
			sx = $urandom_range(1) ? 65535 : 0;
		if ($urandom_range(9) == 0)
			sy = $urandom_range(1) ? 65535 : 0;
		t0 = $urandom;
		if ($urandom_range(19) == 0) begin
			send_frame(make_frame(1'b0, POS_W'($urandom), POS_W'($urandom),
				1'($urandom_range(1)), $urandom));
			sent++;
		end
		send_frame(make_frame(1'b1, POS_W'(sx), POS_W'(sy), 1'b1, t0));
		sent++;
		repeat ($urandom_range(0, 5)) begin
			if ($urandom_range(9) == 0) begin
				send_frame(make_frame(1'b1, POS_W'($urandom), POS_W'($urandom), 1'b0,
					$urandom));
			end else begin
				nx = sx + int'($urandom_range(0, 2 * span)) - span;
				ny = sy + int'($urandom_range(0, 2 * span)) - span;
				nx = nx < 0 ? 0 : (nx > 65535 ? 65535 : nx);
				ny = ny < 0 ? 0 : (ny > 65535 ? 65535 : ny);
				send_frame(make_frame(1'b1, POS_W'(nx), POS_W'(ny), 1'b1,
					t0 + $urandom_range(0, 3000)));
				sent++;
			end
		end
		r = $urandom_range(9);
		if (r == 0)
			held = $urandom;
		else
			held = $urandom_range(0, 2 * int'(hold_cfg) + 2);
		send_frame(make_frame(1'b0, POS_W'($urandom), POS_W'($urandom),
			1'($urandom_range(1)), t0 + held));
		sent++;
	endtask

	task automatic test_reset_defaults();
		// release while nothing is pressed
		send_frame(make_frame(1'b0, 16'd7, 16'd7, 1'b1, 32'd0));
		// failed mapping dropped, extreme corner, hold across timestamp wrap
		send_frame(make_frame(1'b1, 16'd0, 16'd0, 1'b0, 32'd0));
		send_frame(make_frame(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFF0));
		send_frame(make_frame(1'b0, 16'd0, 16'd0, 1'b0, 32'h0000_0010));
		// movement exactly at slop, hold one below the limit
		send_frame(make_frame(1'b1, 16'd100, 16'd100, 1'b1, 32'd1000));
		send_frame(make_frame(1'b1, 16'd124, 16'd76, 1'b1, 32'd1500));
		send_frame(make_frame(1'b0, 16'hFFFF, 16'd0, 1'b1, 32'd2199));
		// moved stays set after returning to start
		send_frame(make_frame(1'b1, 16'd100, 16'd100, 1'b1, 32'd0));
		send_frame(make_frame(1'b1, 16'd125, 16'd100, 1'b1, 32'd1));
		send_frame(make_frame(1'b1, 16'd100, 16'd100, 1'b1, 32'd2));
		send_frame(make_frame(1'b0, 16'd0, 16'd0, 1'b1, 32'd5));
		// hold equal to the limit
		send_frame(make_frame(1'b1, 16'd0, 16'd0, 1'b1, 32'd0));
		send_frame(make_frame(1'b0, 16'd0, 16'd0, 1'b1, 32'd1200));
		// full-scale distance does not wrap
		send_frame(make_frame(1'b1, 16'd0, 16'd0, 1'b1, 32'd0));
		send_frame(make_frame(1'b1, 16'hFFFF, 16'd0, 1'b1, 32'd1));
		send_frame(make_frame(1'b0, 16'd0, 16'd0, 1'b1, 32'd2));
		// failed mapping mid-press leaves the tracked position alone
		send_frame(make_frame(1'b1, 16'd50, 16'd50, 1'b1, 32'd0));
		send_frame(make_frame(1'b1, 16'd60000, 16'd60000, 1'b0, 32'd1));
		send_frame(make_frame(1'b0, 16'd0, 16'd0, 1'b0, 32'd1));
	endtask

	task automatic test_config_extremes();
		write_cfg(REG_MOVE_SLOP, 16'd0);
		write_cfg(REG_MAX_HOLD_MS, 16'd1);
		send_frame(make_frame(1'b1, 16'd10, 16'd10, 1'b1, 32'd5));
		send_frame(make_frame(1'b0, 16'd0, 16'd0, 1'b1, 32'd5));
		send_frame(make_frame(1'b1, 16'd10, 16'd10, 1'b1, 32'd5));
		send_frame(make_frame(1'b1, 16'd11, 16'd10, 1'b1, 32'd5));
		send_frame(make_frame(1'b0, 16'd0, 16'd0, 1'b1, 32'd5));
		// zero hold limit never taps
		write_cfg(REG_MAX_HOLD_MS, 16'd0);
		send_frame(make_frame(1'b1, 16'd10, 16'd10, 1'b1, 32'd9));
		send_frame(make_frame(1'b0, 16'd0, 16'd0, 1'b1, 32'd9));
		write_cfg(REG_MOVE_SLOP, 16'hFFFF);
		write_cfg(REG_MAX_HOLD_MS, 16'hFFFF);
		send_frame(make_frame(1'b1, 16'd0, 16'd0, 1'b1, 32'd0));
		send_frame(make_frame(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 32'd1));
		send_frame(make_frame(1'b0, 16'd0, 16'd0, 1'b1, 32'd65534));
	endtask

	task automatic test_random_phase(input logic [CFG_W-1:0] slop, input logic [CFG_W-1:0] hold,
			input int in_pct, input int out_pct, input int n_frames);
		int sent;
		int total;
		write_cfg(REG_MOVE_SLOP, slop);
		write_cfg(REG_MAX_HOLD_MS, hold);
		in_idle_pct  = in_pct;
		out_idle_pct = out_pct;
		total = 0;
		while (total < n_frames) begin
			play_gesture(sent);
			total += sent;
		end
		in_idle_pct  = 18;
		out_idle_pct = 18;
	endtask

	task automatic test_backpressure();
		logic [TIME_W-1:0] t0;
		write_cfg(REG_MOVE_SLOP, MOVE_SLOP_RST);
		write_cfg(REG_MAX_HOLD_MS, MAX_HOLD_MS_RST);
		in_idle_pct = 0;
		hold_req = 1'b1;
		repeat (30) begin
			t0 = $urandom;
			send_frame(make_frame(1'b1, POS_W'($urandom), POS_W'($urandom), 1'b1, t0));
			send_frame(make_frame(1'b0, POS_W'($urandom), POS_W'($urandom), 1'b1, t0 + 1));
		end
		in_idle_pct = 18;
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			out_stall = ($urandom_range(99) < out_idle_pct);
		end
	end

	always @(posedge clk) begin : check_taps
		tap_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_taps.size() == 0) begin
				$error("unexpected tap transaction: tap_x %0d tap_y %0d", tap_x, tap_y);
				mismatches++;
			end else begin
				want = pending_taps.pop_front();
				if (tap_x !== want.x) begin
					$error("tap_x expected %0d actual %0d", want.x, tap_x);
					mismatches++;
				end
				if (tap_y !== want.y) begin
					$error("tap_y expected %0d actual %0d", want.y, tap_y);
					mismatches++;
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_config_extremes();
		test_random_phase(16'd24, 16'd1200, 18, 18, 300);
		test_random_phase(16'd0, 16'd0, 18, 18, 150);
		test_random_phase(16'hFFFF, 16'hFFFF, 18, 18, 200);
		test_random_phase(16'd0, 16'hFFFF, 18, 18, 200);
		test_random_phase(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
			18, 18, 150);
		test_random_phase(16'd24, 16'd1200, 0, 0, 300);
		test_random_phase(CFG_W'($urandom_range(0, 64)), CFG_W'($urandom_range(1, 3000)),
			18, 18, 250);
		test_random_phase(16'd3, 16'd20, 18, 18, 150);
		test_backpressure();
		drain_frames();
		if (pending_taps.size() == 0 && mismatches == 0) begin
			$display("[touch_tap_detector] OK");
		end else begin
			$display("[touch_tap_detector] ERROR");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("[touch_tap_detector] ERROR");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/ttd_pkg.sv
hw/rtl/ttd_cfg.sv
hw/rtl/ttd_core.sv
hw/rtl/touch_tap_detector.sv
tb/touch_tap_detector_tb.sv
